// ===== rtl/owtm_pkg.sv =====
// owtm_pkg: shared types and constants of the 1-Wire temperature master
`default_nettype none

package owtm_pkg;

  // configuration data width (widest register)
  localparam int CFG_DATA_W = 20;
  localparam int CFG_IDX_W  = 3;

  // command codes carried on the operation field
  typedef enum logic [2:0] {
    OP_TICK  = 3'd0,
    OP_RESET = 3'd1,
    OP_WRITE = 3'd2,
    OP_READ  = 3'd3,
    OP_TEMP  = 3'd4
  } op_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    CFG_RESET_LOW    = 3'd0,
    CFG_PRES_WAIT    = 3'd1,
    CFG_PRES_TAIL    = 3'd2,
    CFG_SLOT         = 3'd3,
    CFG_WR_ONE_LOW   = 3'd4,
    CFG_RD_LOW       = 3'd5,
    CFG_CONVERT_WAIT = 3'd6
  } cfg_idx_t;

  // bus sequencer phases
  typedef enum logic [3:0] {
    PH_IDLE     = 4'd0,
    PH_RST_LOW  = 4'd1,
    PH_RST_WAIT = 4'd2,
    PH_RST_TAIL = 4'd3,
    PH_WR_LOW   = 4'd4,
    PH_WR_REL   = 4'd5,
    PH_RD_LOW   = 4'd6,
    PH_RD_TAIL  = 4'd7,
    PH_CONV     = 4'd8
  } phase_t;

  // temperature sequence steps
  localparam logic [3:0] STEP_RESET_A = 4'd0;
  localparam logic [3:0] STEP_SKIP_A  = 4'd1;
  localparam logic [3:0] STEP_CONVERT = 4'd2;
  localparam logic [3:0] STEP_WAIT    = 4'd3;
  localparam logic [3:0] STEP_RESET_B = 4'd4;
  localparam logic [3:0] STEP_SKIP_B  = 4'd5;
  localparam logic [3:0] STEP_RD_PAD  = 4'd6;
  localparam logic [3:0] STEP_LOW     = 4'd7;
  localparam logic [3:0] STEP_HIGH    = 4'd8;

  // ROM and function command bytes
  localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
  localparam logic [7:0] CMD_CONVERT    = 8'h44;
  localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;

  // register reset values
  localparam logic [9:0]  RST_RESET_LOW    = 10'd480;
  localparam logic [7:0]  RST_PRES_WAIT    = 8'd80;
  localparam logic [9:0]  RST_PRES_TAIL    = 10'd400;
  localparam logic [7:0]  RST_SLOT         = 8'd60;
  localparam logic [3:0]  RST_WR_ONE_LOW   = 4'd1;
  localparam logic [3:0]  RST_RD_LOW       = 4'd2;
  localparam logic [19:0] RST_CONVERT_WAIT = 20'd800000;

endpackage

`default_nettype wire

// ===== rtl/one_wire_temperature_master.sv =====
// one_wire_temperature_master: 1-Wire bus master with temperature read sequence
//
//   channel | direction | handshake          | payload
//   in      | input     | in_valid/in_ready  | operation, write_data, bus_level
//   out     | output    | out_valid/out_ready| drive_low, status, read byte, temperature
//   cfg     | input     | cfg_valid/cfg_ready| cfg_index, cfg_data
//
// One tick per cycle while the output register is not stalled: the sequencer state
// and the result register update on the same edge that takes the tick, so a new tick
// is taken every cycle in which the input is not held off.
// The output register is the only stall point; input is held off only while it is full
// and not being taken. Configuration writes are taken every cycle.
// Reset (rst_n low, synchronous) returns the sequencer to idle and loads default timing.
`default_nettype none

module one_wire_temperature_master #(
  parameter int COUNT_WIDTH = 20
) (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // tick input
  input  wire logic                            in_valid,
  output logic                                 in_ready,
  input  wire logic [2:0]                      in_operation,
  input  wire logic [7:0]                      in_write_data,
  input  wire logic                            in_bus_level,
  // result output
  output logic                                 out_valid,
  input  wire logic                            out_ready,
  output logic                                 out_drive_low,
  output logic                                 out_busy_res,
  output logic                                 out_done_res,
  output logic                                 out_command_rejected,
  output logic                                 out_presence_seen,
  output logic [7:0]                           out_read_byte,
  output logic [15:0]                          out_temp_raw,
  output logic [7:0]                           out_temp_whole,
  output logic [3:0]                           out_temp_frac,
  // configuration writes
  input  wire logic                            cfg_valid,
  output logic                                 cfg_ready,
  input  wire logic [owtm_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [owtm_pkg::CFG_DATA_W-1:0] cfg_data
);

  localparam int TW = (COUNT_WIDTH > owtm_pkg::CFG_DATA_W) ? COUNT_WIDTH
                                                            : owtm_pkg::CFG_DATA_W;
  localparam logic [TW-1:0] CNT_MAX = TW'((64'd1 << COUNT_WIDTH) - 64'd1);

  // configuration registers
  logic [9:0]  cfg_reset_low_r;
  logic [7:0]  cfg_pres_wait_r;
  logic [9:0]  cfg_pres_tail_r;
  logic [7:0]  cfg_slot_r;
  logic [3:0]  cfg_wr_one_low_r;
  logic [3:0]  cfg_rd_low_r;
  logic [19:0] cfg_convert_wait_r;

  // sequencer state
  owtm_pkg::phase_t       phase_r, phase_nxt;
  logic [3:0]             step_r, step_nxt;
  logic [COUNT_WIDTH-1:0] tick_r, tick_nxt;
  logic [2:0]             bit_idx_r, bit_idx_nxt;
  logic [7:0]             shift_r, shift_nxt;
  logic [15:0]            temp_r, temp_nxt;
  logic                   presence_r, presence_nxt;
  logic [2:0]             active_r, active_nxt;
  logic [7:0]             read_res_r, read_res_nxt;
  logic [7:0]             temp_low_r, temp_low_nxt;

  // output register
  logic        out_valid_r;
  logic        drive_r, drive_nxt;
  logic        busy_r;
  logic        done_r, done_nxt;
  logic        rejected_r, rejected_nxt;

  logic in_xfer;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign in_xfer   = in_valid && in_ready;

  // configuration write decode
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_reset_low_r    <= owtm_pkg::RST_RESET_LOW;
      cfg_pres_wait_r    <= owtm_pkg::RST_PRES_WAIT;
      cfg_pres_tail_r    <= owtm_pkg::RST_PRES_TAIL;
      cfg_slot_r         <= owtm_pkg::RST_SLOT;
      cfg_wr_one_low_r   <= owtm_pkg::RST_WR_ONE_LOW;
      cfg_rd_low_r       <= owtm_pkg::RST_RD_LOW;
      cfg_convert_wait_r <= owtm_pkg::RST_CONVERT_WAIT;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        owtm_pkg::CFG_RESET_LOW:    cfg_reset_low_r    <= cfg_data[9:0];
        owtm_pkg::CFG_PRES_WAIT:    cfg_pres_wait_r    <= cfg_data[7:0];
        owtm_pkg::CFG_PRES_TAIL:    cfg_pres_tail_r    <= cfg_data[9:0];
        owtm_pkg::CFG_SLOT:         cfg_slot_r         <= cfg_data[7:0];
        owtm_pkg::CFG_WR_ONE_LOW:   cfg_wr_one_low_r   <= cfg_data[3:0];
        owtm_pkg::CFG_RD_LOW:       cfg_rd_low_r       <= cfg_data[3:0];
        owtm_pkg::CFG_CONVERT_WAIT: cfg_convert_wait_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // one tick of the bus sequencer
  always_comb begin
    owtm_pkg::phase_t       ph;
    logic [3:0]             step;
    logic [COUNT_WIDTH-1:0] tc;
    logic [COUNT_WIDTH-1:0] tc_inc;
    logic [2:0]             bi;
    logic [7:0]             sb;
    logic [2:0]             act;
    logic                   cur_bit;
    logic                   counting;
    logic                   cnt_done;
    logic                   prim_over;
    logic                   cmd;
    logic [owtm_pkg::CFG_DATA_W-1:0] tgt_raw;
    logic [TW-1:0]          tgt;

    ph           = phase_r;
    step         = step_r;
    tc           = tick_r;
    bi           = bit_idx_r;
    sb           = shift_r;
    act          = active_r;
    temp_nxt     = temp_r;
    presence_nxt = presence_r;
    read_res_nxt = read_res_r;
    temp_low_nxt = temp_low_r;
    drive_nxt    = 1'b0;
    done_nxt     = 1'b0;
    rejected_nxt = 1'b0;
    prim_over    = 1'b0;

    // command start or rejection
    cmd = (in_operation == owtm_pkg::OP_RESET) || (in_operation == owtm_pkg::OP_WRITE) ||
          (in_operation == owtm_pkg::OP_READ)  || (in_operation == owtm_pkg::OP_TEMP);
    if (cmd) begin
      if (phase_r != owtm_pkg::PH_IDLE) begin
        rejected_nxt = 1'b1;
      end else begin
        act  = in_operation;
        step = owtm_pkg::STEP_RESET_A;
        tc   = '0;
        bi   = '0;
        case (in_operation)
          owtm_pkg::OP_WRITE: begin
            ph = owtm_pkg::PH_WR_LOW;
            sb = in_write_data;
          end
          owtm_pkg::OP_READ: begin
            ph = owtm_pkg::PH_RD_LOW;
            sb = '0;
          end
          default: ph = owtm_pkg::PH_RST_LOW;
        endcase
      end
    end

    cur_bit = sb[bi];

    // slot length for the current phase
    counting = 1'b1;
    case (ph)
      owtm_pkg::PH_RST_LOW:  tgt_raw = 20'(cfg_reset_low_r);
      owtm_pkg::PH_RST_WAIT: tgt_raw = 20'(cfg_pres_wait_r);
      owtm_pkg::PH_RST_TAIL: tgt_raw = 20'(cfg_pres_tail_r);
      owtm_pkg::PH_WR_LOW:   tgt_raw = cur_bit ? 20'(cfg_wr_one_low_r) : 20'(cfg_slot_r);
      owtm_pkg::PH_WR_REL:   tgt_raw = cur_bit ? 20'(cfg_slot_r) : 20'd1;
      owtm_pkg::PH_RD_LOW:   tgt_raw = 20'(cfg_rd_low_r);
      owtm_pkg::PH_RD_TAIL:  tgt_raw = 20'(cfg_slot_r);
      owtm_pkg::PH_CONV:     tgt_raw = cfg_convert_wait_r;
      default: begin
        tgt_raw  = 20'd1;
        counting = 1'b0;
      end
    endcase
    tgt = TW'(tgt_raw);
    if (tgt == '0) tgt = TW'(1);
    if (tgt > CNT_MAX) tgt = CNT_MAX;

    // read sample on the first released tick
    if (ph == owtm_pkg::PH_RD_TAIL && tc == '0) sb = sb | (8'(in_bus_level) << bi);

    tc_inc   = tc + COUNT_WIDTH'(1);
    cnt_done = counting && (TW'(tc_inc) >= tgt);
    if (counting) tc = cnt_done ? '0 : tc_inc;

    // phase transitions
    unique case (ph)
      owtm_pkg::PH_IDLE: ;
      owtm_pkg::PH_RST_LOW: begin
        drive_nxt = 1'b1;
        if (cnt_done) ph = owtm_pkg::PH_RST_WAIT;
      end
      owtm_pkg::PH_RST_WAIT: begin
        if (cnt_done) begin
          presence_nxt = !in_bus_level;
          ph           = owtm_pkg::PH_RST_TAIL;
        end
      end
      owtm_pkg::PH_RST_TAIL: prim_over = cnt_done;
      owtm_pkg::PH_WR_LOW: begin
        drive_nxt = 1'b1;
        if (cnt_done) ph = owtm_pkg::PH_WR_REL;
      end
      owtm_pkg::PH_WR_REL: begin
        if (cnt_done) begin
          if (bi == 3'd7) begin
            prim_over = 1'b1;
          end else begin
            bi = bi + 3'd1;
            ph = owtm_pkg::PH_WR_LOW;
          end
        end
      end
      owtm_pkg::PH_RD_LOW: begin
        drive_nxt = 1'b1;
        if (cnt_done) ph = owtm_pkg::PH_RD_TAIL;
      end
      owtm_pkg::PH_RD_TAIL: begin
        if (cnt_done) begin
          if (bi == 3'd7) begin
            prim_over = 1'b1;
          end else begin
            bi = bi + 3'd1;
            ph = owtm_pkg::PH_RD_LOW;
          end
        end
      end
      owtm_pkg::PH_CONV: prim_over = cnt_done;
      default: ph = owtm_pkg::PH_IDLE;
    endcase

    // end of a reset, byte or wait: finish or go to the next sequence step
    if (prim_over) begin
      if (act == owtm_pkg::OP_TEMP && step < owtm_pkg::STEP_HIGH) begin
        if (step == owtm_pkg::STEP_LOW) temp_low_nxt = sb;
        step = step + 4'd1;
        tc   = '0;
        bi   = '0;
        case (step)
          owtm_pkg::STEP_RESET_A, owtm_pkg::STEP_RESET_B: ph = owtm_pkg::PH_RST_LOW;
          owtm_pkg::STEP_SKIP_A, owtm_pkg::STEP_SKIP_B: begin
            ph = owtm_pkg::PH_WR_LOW;
            sb = owtm_pkg::CMD_SKIP_ROM;
          end
          owtm_pkg::STEP_CONVERT: begin
            ph = owtm_pkg::PH_WR_LOW;
            sb = owtm_pkg::CMD_CONVERT;
          end
          owtm_pkg::STEP_WAIT: ph = owtm_pkg::PH_CONV;
          owtm_pkg::STEP_RD_PAD: begin
            ph = owtm_pkg::PH_WR_LOW;
            sb = owtm_pkg::CMD_READ_SCRPD;
          end
          default: begin
            ph = owtm_pkg::PH_RD_LOW;
            sb = '0;
          end
        endcase
      end else begin
        if (act == owtm_pkg::OP_READ) read_res_nxt = sb;
        if (act == owtm_pkg::OP_TEMP) temp_nxt = {sb, temp_low_r};
        ph       = owtm_pkg::PH_IDLE;
        tc       = '0;
        step     = '0;
        act      = '0;
        done_nxt = 1'b1;
      end
    end

    phase_nxt   = ph;
    step_nxt    = step;
    tick_nxt    = tc;
    bit_idx_nxt = bi;
    shift_nxt   = sb;
    active_nxt  = act;
  end

  // sequencer state registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= owtm_pkg::PH_IDLE;
      step_r     <= '0;
      tick_r     <= '0;
      bit_idx_r  <= '0;
      shift_r    <= '0;
      temp_r     <= '0;
      presence_r <= 1'b0;
      active_r   <= '0;
      read_res_r <= '0;
      temp_low_r <= '0;
    end else if (in_xfer) begin
      phase_r    <= phase_nxt;
      step_r     <= step_nxt;
      tick_r     <= tick_nxt;
      bit_idx_r  <= bit_idx_nxt;
      shift_r    <= shift_nxt;
      temp_r     <= temp_nxt;
      presence_r <= presence_nxt;
      active_r   <= active_nxt;
      read_res_r <= read_res_nxt;
      temp_low_r <= temp_low_nxt;
    end
  end

  // output register valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (in_xfer) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // output register flags
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      drive_r    <= drive_nxt;
      busy_r     <= (phase_nxt != owtm_pkg::PH_IDLE);
      done_r     <= done_nxt;
      rejected_r <= rejected_nxt;
    end
  end

  assign out_valid            = out_valid_r;
  assign out_drive_low        = drive_r;
  assign out_busy_res         = busy_r;
  assign out_done_res         = done_r;
  assign out_command_rejected = rejected_r;
  assign out_presence_seen    = presence_r;
  assign out_read_byte        = read_res_r;
  assign out_temp_raw         = temp_r;
  assign out_temp_whole       = temp_r[11:4];
  assign out_temp_frac        = temp_r[3:0];

endmodule

`default_nettype wire

// ===== rtl/owtm_checker.sv =====
// owtm_checker: port-level assertions for the 1-Wire temperature master
`default_nettype none

module owtm_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_ready,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic        out_drive_low,
  input wire logic        out_busy_res,
  input wire logic        out_done_res,
  input wire logic [15:0] out_temp_raw,
  input wire logic [7:0]  out_temp_whole,
  input wire logic [3:0]  out_temp_frac
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_drive_low) && $stable(out_busy_res)
                               && $stable(out_done_res) && $stable(out_temp_raw))
    else $error("stalled result changed");

  // an empty output register never holds off ticks
  a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> in_ready)
    else $error("input stalled with empty output register");

  // a finished command leaves the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res)
    else $error("done while still busy");

  // the line is only pulled low inside a running command
  a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_drive_low |-> out_busy_res)
    else $error("line driven while idle");

  // temperature views agree with the raw word
  a_temp_split: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_temp_whole == out_temp_raw[11:4] && out_temp_frac == out_temp_raw[3:0])
    else $error("temperature fields disagree");

endmodule

bind one_wire_temperature_master owtm_checker u_owtm_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_ready       (in_ready),
  .out_valid      (out_valid),
  .out_ready      (out_ready),
  .out_drive_low  (out_drive_low),
  .out_busy_res   (out_busy_res),
  .out_done_res   (out_done_res),
  .out_temp_raw   (out_temp_raw),
  .out_temp_whole (out_temp_whole),
  .out_temp_frac  (out_temp_frac)
);

`default_nettype wire
